>>> rtl/thdepq_pkg.sv
`default_nettype none

package thdepq_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int KEY_W        = 64;
   localparam int PRI_W        = 32;
   localparam int MODE_W       = 3;
   localparam int STATUS_W     = 2;
   localparam int ENTRY_W      = KEY_W + PRI_W;

   localparam logic [MODE_W-1:0] MODE_INSERT     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_CHANGE     = 3'd1;
   localparam logic [MODE_W-1:0] MODE_PEEK       = 3'd2;
   localparam logic [MODE_W-1:0] MODE_REMOVE_MAX = 3'd3;
   localparam logic [MODE_W-1:0] MODE_REMOVE_MIN = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

   typedef enum logic [4:0] {
      ST_IDLE, ST_FREE, ST_SCAN, ST_CH_A, ST_CH_B, ST_CH_C,
      ST_PK_A, ST_PK_B, ST_PK_C, ST_PK_D, ST_RM_A, ST_RM_B, ST_RM_C,
      ST_LD_A, ST_LD_B, ST_LD_C, ST_SU_RD, ST_SU_W1, ST_SU_W2,
      ST_SD_RD, ST_SD_W1, ST_SD_W2, ST_SD_W3, ST_FIN, ST_RESP
   } st_type;

   // Heap order test: strict, so ties never move.
   function automatic logic beats(input logic mx, input logic signed [PRI_W-1:0] a,
                                  input logic signed [PRI_W-1:0] b);
      beats = mx ? (a > b) : (a < b);
   endfunction

endpackage

`default_nettype wire

>>> rtl/twin_heap_double_ended_priority_queue_core.sv
// Twin-heap double-ended priority queue.
// Request channel (req_valid / req_stall) carries one operation per transfer:
// insert, change priority of a key, peek at both ends, remove max, remove min.
// Response channel (rsp_valid / rsp_stall) returns exactly one result per
// request: status, removed or max entry, min entry on peek, entry count.
// Each entry lives in a max-heap and a min-heap kept in single-port-read
// synchronous memories (registered read) with back links per slot.
// Peek reads both roots; remove takes the root and refills the gap in each
// heap; insert scans the free-slot bits and then sifts up both heaps; change
// streams the max heap to find the key and then sifts both heaps.
// One request is processed at a time; a new request transfers while the
// previous response still waits in the output register.
// Reset empties the queue (free bits all set, count zero) and drops any
// pending response. While the receiver stalls, the response holds and the
// block finishes at most one more request, then waits to hand it over.
`default_nettype none

module twin_heap_double_ended_priority_queue_core
   import thdepq_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   localparam int IDX_W   = $clog2(CAPACITY),
   localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire  [MODE_W-1:0]            req_mode,
   input  wire  [KEY_W-1:0]             req_key,
   input  wire  signed [PRI_W-1:0]      req_priority_req,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic [STATUS_W-1:0]          rsp_status,
   output logic [KEY_W-1:0]             rsp_out_key,
   output logic signed [PRI_W-1:0]      rsp_out_priority,
   output logic [KEY_W-1:0]             rsp_min_key,
   output logic signed [PRI_W-1:0]      rsp_min_priority,
   output logic [CNT_W-1:0]             rsp_entry_count
);

   localparam int LW = IDX_W + 2;

   // storage
   logic [ENTRY_W-1:0] entry_mem     [CAPACITY];
   logic [IDX_W-1:0]   max_order_mem [CAPACITY];
   logic [IDX_W-1:0]   min_order_mem [CAPACITY];
   logic [IDX_W-1:0]   max_pos_mem   [CAPACITY];
   logic [IDX_W-1:0]   min_pos_mem   [CAPACITY];

   logic [ENTRY_W-1:0] ent_rd_ff;
   logic [IDX_W-1:0]   max_rd_ff, min_rd_ff, maxpos_rd_ff, minpos_rd_ff;

   // memory port controls
   logic               ent_we, ord_we, pos_we;
   logic [IDX_W-1:0]   ent_addr, ent_waddr, ord_addr, ord_waddr, pos_addr, pos_waddr;
   logic [IDX_W-1:0]   ord_wdata, pos_wdata;
   logic [ENTRY_W-1:0] ent_wdata;

   // control and working registers
   st_type                  state_ff, state_in;
   logic [MODE_W-1:0]       mode_ff, mode_in;
   logic [KEY_W-1:0]        key_ff, key_in;
   logic signed [PRI_W-1:0] pri_ff, pri_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CAPACITY-1:0]     free_ff, free_in;
   logic                    mx_ff, mx_in;
   logic [IDX_W-1:0]        hole_ff, hole_in;
   logic [CNT_W-1:0]        lim_ff, lim_in;
   logic [IDX_W-1:0]        cur_slot_ff, cur_slot_in;
   logic signed [PRI_W-1:0] cur_pri_ff, cur_pri_in;
   logic                    fallback_ff, fallback_in;
   logic                    phase_ff, phase_in;
   logic                    up2_ff, up2_in;
   logic [IDX_W-1:0]        q_ff, q_in;
   logic [IDX_W-1:0]        slot_l_ff, slot_l_in, slot_r_ff, slot_r_in;
   logic signed [PRI_W-1:0] pri_l_ff, pri_l_in;
   logic [IDX_W-1:0]        par_slot_ff, par_slot_in;
   logic [CNT_W-1:0]        scan_ff, scan_in;
   logic                    v1_ff, v1_in, v2_ff, v2_in, found_ff, found_in;
   logic [IDX_W-1:0]        i1_ff, i1_in, i2_ff, i2_in, hit_ff, hit_in;
   logic [IDX_W-1:0]        fs_ff, fs_in;

   // result being built, and the output register
   logic [STATUS_W-1:0]     res_status_ff, res_status_in;
   logic [KEY_W-1:0]        res_key_ff, res_key_in, res_mkey_ff, res_mkey_in;
   logic signed [PRI_W-1:0] res_pri_ff, res_pri_in, res_mpri_ff, res_mpri_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [KEY_W-1:0]        rsp_key_ff, rsp_key_in, rsp_mkey_ff, rsp_mkey_in;
   logic signed [PRI_W-1:0] rsp_pri_ff, rsp_pri_in, rsp_mpri_ff, rsp_mpri_in;
   logic [CNT_W-1:0]        rsp_count_ff, rsp_count_in;

   // derived values
   logic [IDX_W-1:0]        ord_rd, pos_other_rd, hole_m1, parent;
   logic [KEY_W-1:0]        ent_key;
   logic signed [PRI_W-1:0] ent_pri;
   logic [LW-1:0]           l_pos, r_pos, lim_ext;
   logic                    r_ok;
   logic signed [PRI_W-1:0] best_pri;
   logic [IDX_W-1:0]        best_slot, best_pos;
   logic                    best_moved;

   assign ord_rd       = mx_ff ? max_rd_ff : min_rd_ff;
   assign pos_other_rd = mx_ff ? minpos_rd_ff : maxpos_rd_ff;
   assign ent_key      = ent_rd_ff[ENTRY_W-1:PRI_W];
   assign ent_pri      = ent_rd_ff[PRI_W-1:0];
   assign hole_m1      = hole_ff - IDX_W'(1);
   assign parent       = hole_m1 >> 1;
   assign l_pos        = {1'b0, hole_ff, 1'b1};
   assign r_pos        = l_pos + LW'(1);
   assign lim_ext      = LW'(lim_ff);
   assign r_ok         = r_pos < lim_ext;

   // Pick the child that wins against the moving entry; left wins ties.
   always_comb begin
      best_pri   = cur_pri_ff;
      best_slot  = cur_slot_ff;
      best_pos   = hole_ff;
      best_moved = 1'b0;
      if (beats(mx_ff, pri_l_ff, best_pri)) begin
         best_pri   = pri_l_ff;
         best_slot  = slot_l_ff;
         best_pos   = l_pos[IDX_W-1:0];
         best_moved = 1'b1;
      end
      if (r_ok && beats(mx_ff, ent_pri, best_pri)) begin
         best_pri   = ent_pri;
         best_slot  = slot_r_ff;
         best_pos   = r_pos[IDX_W-1:0];
         best_moved = 1'b1;
      end
   end

   // Memories: registered read every cycle, one write port each.
   always_ff @(posedge clock) begin
      if (ent_we) begin
         entry_mem[ent_waddr] <= ent_wdata;
      end
      if (ord_we && mx_ff) begin
         max_order_mem[ord_waddr] <= ord_wdata;
      end
      if (ord_we && !mx_ff) begin
         min_order_mem[ord_waddr] <= ord_wdata;
      end
      if (pos_we && mx_ff) begin
         max_pos_mem[pos_waddr] <= pos_wdata;
      end
      if (pos_we && !mx_ff) begin
         min_pos_mem[pos_waddr] <= pos_wdata;
      end
      ent_rd_ff    <= entry_mem[ent_addr];
      max_rd_ff    <= max_order_mem[ord_addr];
      min_rd_ff    <= min_order_mem[ord_addr];
      maxpos_rd_ff <= max_pos_mem[pos_addr];
      minpos_rd_ff <= min_pos_mem[pos_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         free_ff      <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      pri_ff        <= pri_in;
      mx_ff         <= mx_in;
      hole_ff       <= hole_in;
      lim_ff        <= lim_in;
      cur_slot_ff   <= cur_slot_in;
      cur_pri_ff    <= cur_pri_in;
      fallback_ff   <= fallback_in;
      phase_ff      <= phase_in;
      up2_ff        <= up2_in;
      q_ff          <= q_in;
      slot_l_ff     <= slot_l_in;
      slot_r_ff     <= slot_r_in;
      pri_l_ff      <= pri_l_in;
      par_slot_ff   <= par_slot_in;
      scan_ff       <= scan_in;
      v1_ff         <= v1_in;
      v2_ff         <= v2_in;
      found_ff      <= found_in;
      i1_ff         <= i1_in;
      i2_ff         <= i2_in;
      hit_ff        <= hit_in;
      fs_ff         <= fs_in;
      res_status_ff <= res_status_in;
      res_key_ff    <= res_key_in;
      res_pri_ff    <= res_pri_in;
      res_mkey_ff   <= res_mkey_in;
      res_mpri_ff   <= res_mpri_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_pri_ff    <= rsp_pri_in;
      rsp_mkey_ff   <= rsp_mkey_in;
      rsp_mpri_ff   <= rsp_mpri_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      pri_in        = pri_ff;
      count_in      = count_ff;
      free_in       = free_ff;
      mx_in         = mx_ff;
      hole_in       = hole_ff;
      lim_in        = lim_ff;
      cur_slot_in   = cur_slot_ff;
      cur_pri_in    = cur_pri_ff;
      fallback_in   = fallback_ff;
      phase_in      = phase_ff;
      up2_in        = up2_ff;
      q_in          = q_ff;
      slot_l_in     = slot_l_ff;
      slot_r_in     = slot_r_ff;
      pri_l_in      = pri_l_ff;
      par_slot_in   = par_slot_ff;
      scan_in       = scan_ff;
      v1_in         = 1'b0;
      v2_in         = 1'b0;
      found_in      = found_ff;
      i1_in         = i1_ff;
      i2_in         = i2_ff;
      hit_in        = hit_ff;
      fs_in         = fs_ff;
      res_status_in = res_status_ff;
      res_key_in    = res_key_ff;
      res_pri_in    = res_pri_ff;
      res_mkey_in   = res_mkey_ff;
      res_mpri_in   = res_mpri_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_pri_in    = rsp_pri_ff;
      rsp_mkey_in   = rsp_mkey_ff;
      rsp_mpri_in   = rsp_mpri_ff;
      rsp_count_in  = rsp_count_ff;
      ent_we        = 1'b0;
      ent_waddr     = cur_slot_ff;
      ent_wdata     = {key_ff, pri_ff};
      ent_addr      = '0;
      ord_we        = 1'b0;
      ord_waddr     = hole_ff;
      ord_wdata     = cur_slot_ff;
      ord_addr      = '0;
      pos_we        = 1'b0;
      pos_waddr     = cur_slot_ff;
      pos_wdata     = hole_ff;
      pos_addr      = '0;
      req_stall     = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               mode_in       = req_mode;
               key_in        = req_key;
               pri_in        = req_priority_req;
               res_status_in = STATUS_DONE;
               res_key_in    = '0;
               res_pri_in    = '0;
               res_mkey_in   = '0;
               res_mpri_in   = '0;
               phase_in      = 1'b0;
               unique case (req_mode) inside
                  MODE_INSERT: begin
                     fs_in = '0;
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        res_status_in = STATUS_FULL;
                        state_in      = ST_RESP;
                     end else begin
                        state_in = ST_FREE;
                     end
                  end
                  MODE_CHANGE: begin
                     scan_in  = '0;
                     found_in = 1'b0;
                     mx_in    = 1'b1;
                     state_in = ST_SCAN;
                  end
                  MODE_PEEK, MODE_REMOVE_MAX, MODE_REMOVE_MIN: begin
                     mx_in = (req_mode == MODE_REMOVE_MAX);
                     if (count_ff == '0) begin
                        res_status_in = STATUS_EMPTY;
                        state_in      = ST_RESP;
                     end else if (req_mode == MODE_PEEK) begin
                        state_in = ST_PK_A;
                     end else begin
                        state_in = ST_RM_A;
                     end
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end

         // Insert: find the lowest free slot, then sift up min heap, then max heap.
         ST_FREE: begin
            if (free_ff[fs_ff]) begin
               ent_we          = 1'b1;
               ent_waddr       = fs_ff;
               free_in[fs_ff]  = 1'b0;
               count_in        = count_ff + CNT_W'(1);
               cur_slot_in     = fs_ff;
               cur_pri_in      = pri_ff;
               mx_in           = 1'b0;
               hole_in         = count_ff[IDX_W-1:0];
               fallback_in     = 1'b0;
               state_in        = ST_SU_RD;
            end else begin
               fs_in = fs_ff + IDX_W'(1);
            end
         end

         // Change: stream the max heap, keep the last key match.
         ST_SCAN: begin
            ord_addr = scan_ff[IDX_W-1:0];
            ent_addr = ord_rd;
            v2_in    = v1_ff;
            i2_in    = i1_ff;
            if (scan_ff < count_ff) begin
               v1_in   = 1'b1;
               i1_in   = scan_ff[IDX_W-1:0];
               scan_in = scan_ff + CNT_W'(1);
            end
            if (v2_ff && (ent_key == key_ff)) begin
               hit_in   = i2_ff;
               found_in = 1'b1;
            end
            if (!(scan_ff < count_ff) && !v1_ff && !v2_ff) begin
               if (found_ff) begin
                  state_in = ST_CH_A;
               end else begin
                  res_status_in = STATUS_NOT_FOUND;
                  state_in      = ST_RESP;
               end
            end
         end
         ST_CH_A: begin
            ord_addr = hit_ff;
            state_in = ST_CH_B;
         end
         ST_CH_B: begin
            ent_addr    = ord_rd;
            pos_addr    = ord_rd;
            cur_slot_in = ord_rd;
            state_in    = ST_CH_C;
         end
         ST_CH_C: begin
            ent_we      = 1'b1;
            ent_wdata   = {ent_key, pri_ff};
            q_in        = minpos_rd_ff;
            cur_pri_in  = pri_ff;
            up2_in      = pri_ff < ent_pri;
            hole_in     = hit_ff;
            lim_in      = count_ff;
            fallback_in = 1'b0;
            state_in    = (pri_ff > ent_pri) ? ST_SU_RD : ST_SD_RD;
         end

         ST_PK_A: begin
            state_in = ST_PK_B;
         end
         ST_PK_B: begin
            ent_addr    = max_rd_ff;
            cur_slot_in = min_rd_ff;
            state_in    = ST_PK_C;
         end
         ST_PK_C: begin
            res_key_in = ent_key;
            res_pri_in = ent_pri;
            ent_addr   = cur_slot_ff;
            state_in   = ST_PK_D;
         end
         ST_PK_D: begin
            res_mkey_in = ent_key;
            res_mpri_in = ent_pri;
            state_in    = ST_RESP;
         end

         // Remove: take the root, then fill the gap in each heap with its last entry.
         ST_RM_A: begin
            state_in = ST_RM_B;
         end
         ST_RM_B: begin
            ent_addr    = ord_rd;
            pos_addr    = ord_rd;
            cur_slot_in = ord_rd;
            state_in    = ST_RM_C;
         end
         ST_RM_C: begin
            res_key_in           = ent_key;
            res_pri_in           = ent_pri;
            q_in                 = pos_other_rd;
            free_in[cur_slot_ff] = 1'b1;
            count_in             = count_ff - CNT_W'(1);
            lim_in               = count_ff - CNT_W'(1);
            hole_in              = '0;
            fallback_in          = 1'b1;
            state_in             = (count_ff == CNT_W'(1)) ? ST_RESP : ST_LD_A;
         end
         ST_LD_A: begin
            ord_addr = lim_ff[IDX_W-1:0];
            state_in = ST_LD_B;
         end
         ST_LD_B: begin
            cur_slot_in = ord_rd;
            ent_addr    = ord_rd;
            state_in    = ST_LD_C;
         end
         ST_LD_C: begin
            cur_pri_in = ent_pri;
            state_in   = ST_SU_RD;
         end

         // Sift up with a hole; a removal falls back to sift down if the
         // first parent test does not move.
         ST_SU_RD: begin
            if (hole_ff == '0) begin
               state_in = fallback_ff ? ST_SD_RD : ST_FIN;
            end else begin
               ord_addr = parent;
               state_in = ST_SU_W1;
            end
         end
         ST_SU_W1: begin
            par_slot_in = ord_rd;
            ent_addr    = ord_rd;
            state_in    = ST_SU_W2;
         end
         ST_SU_W2: begin
            if (beats(mx_ff, cur_pri_ff, ent_pri)) begin
               ord_we      = 1'b1;
               ord_wdata   = par_slot_ff;
               pos_we      = 1'b1;
               pos_waddr   = par_slot_ff;
               hole_in     = parent;
               fallback_in = 1'b0;
               state_in    = ST_SU_RD;
            end else begin
               state_in = fallback_ff ? ST_SD_RD : ST_FIN;
            end
         end

         ST_SD_RD: begin
            if (l_pos < lim_ext) begin
               ord_addr = l_pos[IDX_W-1:0];
               state_in = ST_SD_W1;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_SD_W1: begin
            slot_l_in = ord_rd;
            ent_addr  = ord_rd;
            ord_addr  = r_pos[IDX_W-1:0];
            state_in  = ST_SD_W2;
         end
         ST_SD_W2: begin
            pri_l_in  = ent_pri;
            slot_r_in = ord_rd;
            ent_addr  = ord_rd;
            state_in  = ST_SD_W3;
         end
         ST_SD_W3: begin
            if (best_moved) begin
               ord_we    = 1'b1;
               ord_wdata = best_slot;
               pos_we    = 1'b1;
               pos_waddr = best_slot;
               hole_in   = best_pos;
               state_in  = ST_SD_RD;
            end else begin
               state_in = ST_FIN;
            end
         end

         // Drop the moving entry in the hole, then start the other heap or respond.
         ST_FIN: begin
            ord_we = 1'b1;
            pos_we = 1'b1;
            if (phase_ff) begin
               state_in = ST_RESP;
            end else begin
               phase_in    = 1'b1;
               mx_in       = !mx_ff;
               fallback_in = 1'b0;
               case (mode_ff) inside
                  MODE_INSERT: begin
                     hole_in  = IDX_W'(count_ff - CNT_W'(1));
                     state_in = ST_SU_RD;
                  end
                  MODE_CHANGE: begin
                     hole_in  = q_ff;
                     state_in = up2_ff ? ST_SU_RD : ST_SD_RD;
                  end
                  MODE_REMOVE_MAX, MODE_REMOVE_MIN: begin
                     hole_in     = q_ff;
                     fallback_in = 1'b1;
                     state_in    = (CNT_W'(q_ff) < lim_ff) ? ST_LD_A : ST_RESP;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end

         // Hand the result to the output register once it is free.
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_key_in    = res_key_ff;
               rsp_pri_in    = res_pri_ff;
               rsp_mkey_in   = res_mkey_ff;
               rsp_mpri_in   = res_mpri_ff;
               rsp_count_in  = count_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_key      = rsp_key_ff;
   assign rsp_out_priority = rsp_pri_ff;
   assign rsp_min_key      = rsp_mkey_ff;
   assign rsp_min_priority = rsp_mpri_ff;
   assign rsp_entry_count  = rsp_count_ff;

endmodule

`default_nettype wire

>>> rtl/thdepq_checker.sv
`default_nettype none

module thdepq_checker
   import thdepq_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
   input wire                     clock,
   input wire                     reset,
   input wire                     rsp_valid,
   input wire                     rsp_stall,
   input wire [STATUS_W-1:0]      rsp_status,
   input wire [KEY_W-1:0]         rsp_out_key,
   input wire [CNT_W-1:0]         rsp_entry_count
);

   // drop any pending response at reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // hold a stalled response
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_key))
      else $error("stalled response changed");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_count <= CNT_W'(CAPACITY))
      else $error("entry count beyond capacity");

   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |-> rsp_entry_count == CNT_W'(CAPACITY))
      else $error("full status with room left");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EMPTY |-> rsp_entry_count == '0 && rsp_out_key == '0)
      else $error("empty status with entries or data");

endmodule

bind twin_heap_double_ended_priority_queue_core thdepq_checker #(.CAPACITY(CAPACITY)) u_chk (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_out_key     (rsp_out_key),
   .rsp_entry_count (rsp_entry_count)
);

`default_nettype wire

>>> tb/tb_twin_heap_double_ended_priority_queue_core.sv
`default_nettype none

// Expected-result store and twin-heap predictor for the queue core.
class dep_queue_scoreboard;
   localparam int CAP = 64;

   logic [63:0]        ent_key [CAP];
   logic signed [31:0] ent_pri [CAP];
   int                 max_ord [CAP];
   int                 min_ord [CAP];
   int                 max_pos [CAP];
   int                 min_pos [CAP];
   bit                 slot_free [CAP];
   int                 live;

   typedef struct packed {
      logic [1:0]         status;
      logic [63:0]        out_key;
      logic signed [31:0] out_pri;
      logic [63:0]        min_key;
      logic signed [31:0] min_pri;
      logic [6:0]         count;
   } outcome_type;

   outcome_type pending_outcomes[$];
   int          mismatches;
   int          results_seen;
   int          status_hits [4];

   function new();
      live = 0;
      mismatches = 0;
      results_seen = 0;
      foreach (slot_free[i]) slot_free[i] = 1'b1;
      foreach (status_hits[i]) status_hits[i] = 0;
   endfunction

   function bit wins(bit mx, int sa, int sb);
      return mx ? (ent_pri[sa] > ent_pri[sb]) : (ent_pri[sa] < ent_pri[sb]);
   endfunction

   function void put(bit mx, int p, int slot);
      if (mx) begin
         max_ord[p] = slot;
         max_pos[slot] = p;
      end else begin
         min_ord[p] = slot;
         min_pos[slot] = p;
      end
   endfunction

   function int at(bit mx, int p);
      return mx ? max_ord[p] : min_ord[p];
   endfunction

   function void bubble_up(bit mx, int p);
      int par, a, b;
      while (p > 0) begin
         par = (p - 1) / 2;
         a = at(mx, p);
         b = at(mx, par);
         if (!wins(mx, a, b)) break;
         put(mx, par, a);
         put(mx, p, b);
         p = par;
      end
   endfunction

   function void bubble_down(bit mx, int p, int n);
      int best, l, r, a, b;
      forever begin
         best = p;
         l = 2 * p + 1;
         r = 2 * p + 2;
         if (l < n && wins(mx, at(mx, l), at(mx, best))) best = l;
         if (r < n && wins(mx, at(mx, r), at(mx, best))) best = r;
         if (best == p) break;
         a = at(mx, p);
         b = at(mx, best);
         put(mx, best, a);
         put(mx, p, b);
         p = best;
      end
   endfunction

   // Fill the gap at p with the last element, then restore order either way.
   function void pull_out(bit mx, int p, int n);
      if (p >= n) return;
      put(mx, p, at(mx, n));
      if (p > 0 && wins(mx, at(mx, p), at(mx, (p - 1) / 2))) bubble_up(mx, p);
      else bubble_down(mx, p, n);
   endfunction

   // Note an accepted request: apply it to the model, queue its result.
   function void note_request(logic [2:0] mode, logic [63:0] key, logic signed [31:0] pri);
      outcome_type o;
      int s, q, hit, m;
      bit found, from_max;
      logic signed [31:0] old;
      o = '0;
      o.status = thdepq_pkg::STATUS_DONE;
      case (mode) inside
         thdepq_pkg::MODE_INSERT: begin
            if (live >= CAP) o.status = thdepq_pkg::STATUS_FULL;
            else begin
               s = 0;
               while (!slot_free[s]) s++;
               slot_free[s] = 1'b0;
               ent_key[s] = key;
               ent_pri[s] = pri;
               put(1'b0, live, s);
               put(1'b1, live, s);
               bubble_up(1'b0, live);
               bubble_up(1'b1, live);
               live++;
            end
         end
         thdepq_pkg::MODE_CHANGE: begin
            found = 1'b0;
            hit = 0;
            for (int i = 0; i < live; i++)
               if (ent_key[max_ord[i]] == key) begin
                  hit = i;
                  found = 1'b1;
               end
            if (!found) o.status = thdepq_pkg::STATUS_NOT_FOUND;
            else begin
               s = max_ord[hit];
               q = min_pos[s];
               old = ent_pri[s];
               ent_pri[s] = pri;
               if (pri < old) bubble_down(1'b1, hit, live);
               else if (pri > old) bubble_up(1'b1, hit);
               if (pri < old) bubble_up(1'b0, q);
               else bubble_down(1'b0, q, live);
            end
         end
         thdepq_pkg::MODE_PEEK, thdepq_pkg::MODE_REMOVE_MAX,
         thdepq_pkg::MODE_REMOVE_MIN: begin
            if (live == 0) o.status = thdepq_pkg::STATUS_EMPTY;
            else if (mode == thdepq_pkg::MODE_PEEK) begin
               o.out_key = ent_key[max_ord[0]];
               o.out_pri = ent_pri[max_ord[0]];
               o.min_key = ent_key[min_ord[0]];
               o.min_pri = ent_pri[min_ord[0]];
            end else begin
               from_max = (mode == thdepq_pkg::MODE_REMOVE_MAX);
               s = at(from_max, 0);
               q = from_max ? min_pos[s] : max_pos[s];
               m = live - 1;
               o.out_key = ent_key[s];
               o.out_pri = ent_pri[s];
               pull_out(from_max, 0, m);
               pull_out(!from_max, q, m);
               live = m;
               slot_free[s] = 1'b1;
            end
         end
         default: ;
      endcase
      o.count = live[6:0];
      pending_outcomes.push_back(o);
   endfunction

   // Compare one result with the oldest pending outcome.
   function void check_result(outcome_type got);
      outcome_type e;
      results_seen++;
      if (pending_outcomes.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result %p", got);
         return;
      end
      e = pending_outcomes.pop_front();
      status_hits[got.status]++;
      if (got !== e) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", e, got);
      end
   endfunction
endclass

module tb_twin_heap_double_ended_priority_queue_core;
   import thdepq_pkg::*;

   localparam int CAP        = 64;
   localparam int IDLE_LIMIT = 20000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [MODE_W-1:0]   req_mode = '0;
   logic [KEY_W-1:0]    req_key = '0;
   logic signed [PRI_W-1:0] req_priority_req = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [KEY_W-1:0]    rsp_out_key;
   logic signed [PRI_W-1:0] rsp_out_priority;
   logic [KEY_W-1:0]    rsp_min_key;
   logic signed [PRI_W-1:0] rsp_min_priority;
   logic [6:0]          rsp_entry_count;

   dep_queue_scoreboard board;

   // Stall controls shared between the stimulus and the receiver process.
   bit quiet_tail = 1'b0;       // no idling on either side in the last part
   int long_hold = 0;           // cycles the receiver must hold off
   int idle_cycles = 0;
   int items_sent = 0;
   bit done = 1'b0;

   twin_heap_double_ended_priority_queue_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mode(req_mode),
      .req_key(req_key),
      .req_priority_req(req_priority_req),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_out_key(rsp_out_key),
      .rsp_out_priority(rsp_out_priority),
      .rsp_min_key(rsp_min_key),
      .rsp_min_priority(rsp_min_priority),
      .rsp_entry_count(rsp_entry_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Sample both channels at the edge; the driven values change only after
   // the nonblocking updates of this edge, so sampling here is race free.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            board.note_request(req_mode, req_key, req_priority_req);
         if (rsp_valid && !rsp_stall)
            board.check_result({rsp_status, rsp_out_key, rsp_out_priority,
                                rsp_min_key, rsp_min_priority, rsp_entry_count});
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   // Watchdog: end the run if no transfer happens for too long.
   always @(posedge clock) begin
      if (idle_cycles >= IDLE_LIMIT && !done) begin
         $display("watchdog expired, %0d results outstanding",
                  board.pending_outcomes.size());
         $display("FAIL");
         $finish;
      end
   end

   // Receiver: random stall bursts, a long hold on request, none at the tail.
   initial begin : receiver
      int burst;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (long_hold) @(posedge clock);
            long_hold = 0;
            rsp_stall <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 10);
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offer one request and hold it until it transfers.
   task automatic send_op(logic [2:0] mode, logic [63:0] key, logic signed [31:0] pri);
      req_valid <= 1'b1;
      req_mode <= mode;
      req_key <= key;
      req_priority_req <= pri;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // Drop valid for a random burst, sometimes.
   task automatic maybe_gap();
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending_outcomes.size() != 0) @(posedge clock);
   endtask

   function automatic logic [63:0] rand_key64();
      return {$urandom(), $urandom()};
   endfunction

   // Pick a key from a small pool most of the time so changes find entries
   // and duplicates appear; sometimes a fully random key.
   function automatic logic [63:0] pool_key();
      if ($urandom_range(0, 9) == 0) return rand_key64();
      return 64'h0123_4567_0000_0000 | 64'($urandom_range(0, 40));
   endfunction

   function automatic logic signed [31:0] rand_pri();
      case ($urandom_range(0, 5))
         0: return 32'sh7fff_ffff;
         1: return 32'sh8000_0000;
         2: return 32'($urandom_range(0, 15)) - 32'sd8;   // frequent ties
         default: return $urandom();
      endcase
   endfunction

   task automatic random_op();
      int pick;
      logic [2:0] mode;
      pick = $urandom_range(0, 99);
      if (pick < 34) mode = MODE_INSERT;
      else if (pick < 52) mode = MODE_CHANGE;
      else if (pick < 66) mode = MODE_PEEK;
      else if (pick < 80) mode = MODE_REMOVE_MAX;
      else if (pick < 96) mode = MODE_REMOVE_MIN;
      else mode = 3'($urandom_range(5, 7));
      send_op(mode, pool_key(), rand_pri());
   endtask

   initial begin : stimulus
      board = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty cases, extremes, duplicates, ties, undefined modes.
      send_op(MODE_PEEK, '0, '0);
      send_op(MODE_REMOVE_MAX, '1, '1);
      send_op(MODE_REMOVE_MIN, '0, '0);
      send_op(MODE_CHANGE, 64'h55, 32'sd3);
      send_op(MODE_INSERT, '1, 32'sh7fff_ffff);
      send_op(MODE_INSERT, '0, 32'sh8000_0000);
      send_op(MODE_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 32'sd0);
      send_op(MODE_INSERT, 64'h5555_5555_5555_5555, 32'sd0);
      send_op(MODE_INSERT, 64'h5555_5555_5555_5555, -32'sd1);
      send_op(MODE_PEEK, '0, '0);
      send_op(MODE_CHANGE, 64'h5555_5555_5555_5555, 32'sd9);
      send_op(MODE_CHANGE, 64'h5555_5555_5555_5555, 32'sd9);
      send_op(MODE_CHANGE, '1, 32'sh8000_0000);
      send_op(MODE_CHANGE, 64'h1234, 32'sd1);
      send_op(3'd5, '1, '1);
      send_op(3'd7, '0, '0);
      send_op(MODE_PEEK, '0, '0);
      send_op(MODE_REMOVE_MAX, '0, '0);
      send_op(MODE_REMOVE_MIN, '0, '0);
      send_op(MODE_REMOVE_MAX, '0, '0);
      send_op(MODE_REMOVE_MIN, '0, '0);
      send_op(MODE_REMOVE_MIN, '0, '0);

      // Fill to capacity and try two more inserts, with the receiver held off
      // long enough that the block backs up and stalls the request side.
      long_hold = 300;
      for (int i = 0; i < CAP + 2; i++) send_op(MODE_INSERT, rand_key64(), rand_pri());
      drain();

      // Random part: bursts of inserts and removes so the queue swings
      // between empty and full, with one pause until all results are back.
      for (int n = 0; n < 1750; n++) begin
         if (n == 900) drain();
         if (n == 1500) quiet_tail = 1'b1;
         if ((n / 150) % 3 == 0 && $urandom_range(0, 1))
            send_op(MODE_INSERT, pool_key(), rand_pri());
         else if ((n / 150) % 3 == 2 && $urandom_range(0, 1))
            send_op($urandom_range(0, 1) ? MODE_REMOVE_MAX : MODE_REMOVE_MIN, '0, '0);
         else random_op();
         maybe_gap();
      end
      drain();
      repeat (200) @(posedge clock);
      done = 1'b1;

      $display("%0d requests sent, %0d results checked", items_sent, board.results_seen);
      $display("statuses: done %0d, full %0d, empty %0d, missing key %0d",
               board.status_hits[0], board.status_hits[1], board.status_hits[2],
               board.status_hits[3]);
      if (board.mismatches == 0 && board.pending_outcomes.size() == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches", board.mismatches);
         $display("FAIL");
      end
      $finish;
   end
endmodule

`default_nettype wire

>>> twin_heap_double_ended_priority_queue_core.f
rtl/thdepq_pkg.sv
rtl/twin_heap_double_ended_priority_queue_core.sv
rtl/thdepq_checker.sv
tb/tb_twin_heap_double_ended_priority_queue_core.sv
